@@ sv/snbt_pkg.sv @@
`default_nettype none

package snbt_pkg;

  localparam int COORD_BITS    = 24;
  localparam int FRAC_BITS     = 16;
  localparam logic [FRAC_BITS-1:0] INFLATE_RESET = FRAC_BITS'(7);

  // Doubled-scale vector components (center minus endpoint, segment direction).
  localparam int VEC_BITS      = COORD_BITS + 2;
  localparam int PROD_BITS     = 2 * VEC_BITS;
  localparam int SUM_BITS      = 2 * VEC_BITS;
  localparam int DOT_BITS      = SUM_BITS + 1;
  localparam int HALF_BITS     = SUM_BITS / 2;
  localparam int K_BITS        = FRAC_BITS + 1;
  localparam int PK_BITS       = HALF_BITS + K_BITS;
  localparam int RK_BITS       = SUM_BITS + K_BITS;
  localparam int WIDE_BITS     = 2 * SUM_BITS;
  localparam int Q_BITS        = RK_BITS + HALF_BITS;
  localparam int RHS_BITS      = RK_BITS + SUM_BITS;

  localparam int FRONT_STAGES  = 3;
  localparam int BACK_STAGES   = 6;
  localparam int STAGES        = FRONT_STAGES + BACK_STAGES;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] seg_a_x;
    logic signed [COORD_BITS-1:0] seg_a_y;
    logic signed [COORD_BITS-1:0] seg_a_z;
    logic signed [COORD_BITS-1:0] seg_b_x;
    logic signed [COORD_BITS-1:0] seg_b_y;
    logic signed [COORD_BITS-1:0] seg_b_z;
    logic signed [COORD_BITS-1:0] box_lo_x;
    logic signed [COORD_BITS-1:0] box_lo_y;
    logic signed [COORD_BITS-1:0] box_lo_z;
    logic signed [COORD_BITS-1:0] box_hi_x;
    logic signed [COORD_BITS-1:0] box_hi_y;
    logic signed [COORD_BITS-1:0] box_hi_z;
  } item_t;

  typedef struct packed {
    logic near;
  } result_t;

  // Dot products handed from the front half of the pipeline to the back half.
  typedef struct packed {
    logic                       rej;
    logic [SUM_BITS-1:0]        r2;
    logic signed [DOT_BITS-1:0] dot;
    logic [SUM_BITS-1:0]        len2;
    logic [SUM_BITS-1:0]        ww;
    logic [SUM_BITS-1:0]        ee;
  } sums_t;

endpackage

`default_nettype wire

@@ sv/snbt_item_if.sv @@
`default_nettype none

interface snbt_item_if;
  logic             valid;
  logic             ready;
  snbt_pkg::item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/snbt_result_if.sv @@
`default_nettype none

interface snbt_result_if;
  logic               valid;
  logic               ready;
  snbt_pkg::result_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/snbt_front.sv @@
`default_nettype none

module snbt_front (
  input  logic                                 clk,
  input  logic [snbt_pkg::FRONT_STAGES-1:0]    load,
  input  snbt_pkg::item_t                      item,
  output snbt_pkg::sums_t                      sums
);

  logic signed [snbt_pkg::COORD_BITS-1:0] pt_a   [3];
  logic signed [snbt_pkg::COORD_BITS-1:0] pt_b   [3];
  logic signed [snbt_pkg::COORD_BITS-1:0] box_lo [3];
  logic signed [snbt_pkg::COORD_BITS-1:0] box_hi [3];
  logic [2:0]                             axis_rej;

  logic                                   s1_rej;
  logic signed [snbt_pkg::VEC_BITS-1:0]   s1_w [3];
  logic signed [snbt_pkg::VEC_BITS-1:0]   s1_d [3];
  logic signed [snbt_pkg::VEC_BITS-1:0]   s1_e [3];
  logic signed [snbt_pkg::VEC_BITS-1:0]   s1_h [3];

  logic                                   s2_rej;
  logic signed [snbt_pkg::PROD_BITS-1:0]  s2_hh [3];
  logic signed [snbt_pkg::PROD_BITS-1:0]  s2_wd [3];
  logic signed [snbt_pkg::PROD_BITS-1:0]  s2_dd [3];
  logic signed [snbt_pkg::PROD_BITS-1:0]  s2_ww [3];
  logic signed [snbt_pkg::PROD_BITS-1:0]  s2_ee [3];

  always_comb begin
    pt_a[0]   = item.seg_a_x;
    pt_a[1]   = item.seg_a_y;
    pt_a[2]   = item.seg_a_z;
    pt_b[0]   = item.seg_b_x;
    pt_b[1]   = item.seg_b_y;
    pt_b[2]   = item.seg_b_z;
    box_lo[0] = item.box_lo_x;
    box_lo[1] = item.box_lo_y;
    box_lo[2] = item.box_lo_z;
    box_hi[0] = item.box_hi_x;
    box_hi[1] = item.box_hi_y;
    box_hi[2] = item.box_hi_z;
  end

  // Slab test: the segment's extent on each axis must touch the box's extent.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      axis_rej[i] = (((pt_a[i] < pt_b[i]) ? pt_a[i] : pt_b[i]) > box_hi[i]) ||
                    (((pt_a[i] < pt_b[i]) ? pt_b[i] : pt_a[i]) < box_lo[i]);
    end
  end

  // Stage 1: everything at doubled scale so the box center stays exact.
  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_rej <= |axis_rej;
      for (int i = 0; i < 3; i++) begin
        s1_w[i] <= snbt_pkg::VEC_BITS'(box_lo[i]) + snbt_pkg::VEC_BITS'(box_hi[i])
                   - (snbt_pkg::VEC_BITS'(pt_a[i]) <<< 1);
        s1_d[i] <= (snbt_pkg::VEC_BITS'(pt_b[i]) - snbt_pkg::VEC_BITS'(pt_a[i])) <<< 1;
        s1_e[i] <= snbt_pkg::VEC_BITS'(box_lo[i]) + snbt_pkg::VEC_BITS'(box_hi[i])
                   - (snbt_pkg::VEC_BITS'(pt_b[i]) <<< 1);
        s1_h[i] <= snbt_pkg::VEC_BITS'(box_hi[i]) - snbt_pkg::VEC_BITS'(box_lo[i]);
      end
    end
  end

  // Stage 2: one signed product per component and per dot product.
  always_ff @(posedge clk) begin
    if (load[1]) begin
      s2_rej <= s1_rej;
      for (int i = 0; i < 3; i++) begin
        s2_hh[i] <= snbt_pkg::PROD_BITS'(s1_h[i] * s1_h[i]);
        s2_wd[i] <= snbt_pkg::PROD_BITS'(s1_w[i] * s1_d[i]);
        s2_dd[i] <= snbt_pkg::PROD_BITS'(s1_d[i] * s1_d[i]);
        s2_ww[i] <= snbt_pkg::PROD_BITS'(s1_w[i] * s1_w[i]);
        s2_ee[i] <= snbt_pkg::PROD_BITS'(s1_e[i] * s1_e[i]);
      end
    end
  end

  // Stage 3: component sums. Squares are never negative, so they add unsigned.
  always_ff @(posedge clk) begin
    if (load[2]) begin
      sums.rej  <= s2_rej;
      sums.r2   <= $unsigned(s2_hh[0]) + $unsigned(s2_hh[1]) + $unsigned(s2_hh[2]);
      sums.dot  <= snbt_pkg::DOT_BITS'(s2_wd[0]) + snbt_pkg::DOT_BITS'(s2_wd[1])
                   + snbt_pkg::DOT_BITS'(s2_wd[2]);
      sums.len2 <= $unsigned(s2_dd[0]) + $unsigned(s2_dd[1]) + $unsigned(s2_dd[2]);
      sums.ww   <= $unsigned(s2_ww[0]) + $unsigned(s2_ww[1]) + $unsigned(s2_ww[2]);
      sums.ee   <= $unsigned(s2_ee[0]) + $unsigned(s2_ee[1]) + $unsigned(s2_ee[2]);
    end
  end

endmodule

`default_nettype wire

@@ sv/snbt_back.sv @@
`default_nettype none

module snbt_back (
  input  logic                                clk,
  input  logic [snbt_pkg::BACK_STAGES-1:0]    load,
  input  logic [snbt_pkg::FRAC_BITS-1:0]      inflate_frac,
  input  snbt_pkg::sums_t                     sums,
  output logic                                near
);

  logic                                 before_a;
  logic                                 past_b;
  logic [snbt_pkg::K_BITS-1:0]          scale_k;
  logic [snbt_pkg::SUM_BITS-1:0]        num;

  logic                                 s4_rej;
  logic                                 s4_general;
  logic [snbt_pkg::SUM_BITS-1:0]        s4_sel;
  logic [snbt_pkg::SUM_BITS-1:0]        s4_len2;
  logic [snbt_pkg::PK_BITS-1:0]         s4_pk [2];
  logic [snbt_pkg::SUM_BITS-1:0]        s4_wl [4];
  logic [snbt_pkg::SUM_BITS-1:0]        s4_nn [3];

  logic                                 s5_rej;
  logic                                 s5_general;
  logic [snbt_pkg::SUM_BITS-1:0]        s5_sel;
  logic [snbt_pkg::SUM_BITS-1:0]        s5_len2;
  logic [snbt_pkg::RK_BITS-1:0]         s5_rk;
  logic [snbt_pkg::WIDE_BITS-1:0]       s5_wl;
  logic [snbt_pkg::WIDE_BITS-1:0]       s5_nn;

  logic                                 s6_rej;
  logic                                 s6_general;
  logic                                 s6_near_end;
  logic [snbt_pkg::SUM_BITS-1:0]        s6_p [3][2];
  logic [snbt_pkg::WIDE_BITS-1:0]       s6_wl;
  logic [snbt_pkg::WIDE_BITS-1:0]       s6_nn;

  logic                                 s7_rej;
  logic                                 s7_general;
  logic                                 s7_near_end;
  logic [snbt_pkg::Q_BITS-1:0]          s7_q [2];
  logic [snbt_pkg::WIDE_BITS-1:0]       s7_diff;

  logic                                 s8_rej;
  logic                                 s8_general;
  logic                                 s8_near_end;
  logic [snbt_pkg::RHS_BITS-1:0]        s8_rhs;
  logic [snbt_pkg::WIDE_BITS-1:0]       s8_diff;

  // The projection falls at or before the first endpoint (this also covers a
  // zero-length segment), or at or past the second one.
  always_comb begin
    before_a = sums.dot[snbt_pkg::DOT_BITS-1] || (sums.dot == '0);
    past_b   = !sums.dot[snbt_pkg::DOT_BITS-1] &&
               (sums.dot[snbt_pkg::SUM_BITS-1:0] >= sums.len2);
    scale_k  = {1'b1, inflate_frac};
    num      = sums.dot[snbt_pkg::SUM_BITS-1:0];
  end

  // Stage 4: pick the endpoint case and start the split wide products.
  always_ff @(posedge clk) begin
    if (load[0]) begin
      s4_rej     <= sums.rej;
      s4_general <= !before_a && !past_b;
      s4_sel     <= before_a ? sums.ww : sums.ee;
      s4_len2    <= sums.len2;
      s4_pk[0]   <= snbt_pkg::PK_BITS'(sums.r2[0 +: snbt_pkg::HALF_BITS] * scale_k);
      s4_pk[1]   <= snbt_pkg::PK_BITS'(sums.r2[snbt_pkg::HALF_BITS +: snbt_pkg::HALF_BITS]
                                       * scale_k);
      s4_wl[0]   <= snbt_pkg::SUM_BITS'(sums.ww[0 +: snbt_pkg::HALF_BITS]
                                        * sums.len2[0 +: snbt_pkg::HALF_BITS]);
      s4_wl[1]   <= snbt_pkg::SUM_BITS'(sums.ww[0 +: snbt_pkg::HALF_BITS]
                    * sums.len2[snbt_pkg::HALF_BITS +: snbt_pkg::HALF_BITS]);
      s4_wl[2]   <= snbt_pkg::SUM_BITS'(sums.ww[snbt_pkg::HALF_BITS +: snbt_pkg::HALF_BITS]
                    * sums.len2[0 +: snbt_pkg::HALF_BITS]);
      s4_wl[3]   <= snbt_pkg::SUM_BITS'(sums.ww[snbt_pkg::HALF_BITS +: snbt_pkg::HALF_BITS]
                    * sums.len2[snbt_pkg::HALF_BITS +: snbt_pkg::HALF_BITS]);
      s4_nn[0]   <= snbt_pkg::SUM_BITS'(num[0 +: snbt_pkg::HALF_BITS]
                                        * num[0 +: snbt_pkg::HALF_BITS]);
      s4_nn[1]   <= snbt_pkg::SUM_BITS'(num[0 +: snbt_pkg::HALF_BITS]
                                        * num[snbt_pkg::HALF_BITS +: snbt_pkg::HALF_BITS]);
      s4_nn[2]   <= snbt_pkg::SUM_BITS'(num[snbt_pkg::HALF_BITS +: snbt_pkg::HALF_BITS]
                                        * num[snbt_pkg::HALF_BITS +: snbt_pkg::HALF_BITS]);
    end
  end

  // Stage 5: assemble the inflated radius and the two wide products.
  always_ff @(posedge clk) begin
    if (load[1]) begin
      s5_rej     <= s4_rej;
      s5_general <= s4_general;
      s5_sel     <= s4_sel;
      s5_len2    <= s4_len2;
      s5_rk      <= snbt_pkg::RK_BITS'(s4_pk[0])
                    + (snbt_pkg::RK_BITS'(s4_pk[1]) << snbt_pkg::HALF_BITS);
      s5_wl      <= snbt_pkg::WIDE_BITS'(s4_wl[0])
                    + (snbt_pkg::WIDE_BITS'(s4_wl[1]) << snbt_pkg::HALF_BITS)
                    + (snbt_pkg::WIDE_BITS'(s4_wl[2]) << snbt_pkg::HALF_BITS)
                    + (snbt_pkg::WIDE_BITS'(s4_wl[3]) << (2 * snbt_pkg::HALF_BITS));
      // The cross term of a square appears twice, hence the extra bit of shift.
      s5_nn      <= snbt_pkg::WIDE_BITS'(s4_nn[0])
                    + (snbt_pkg::WIDE_BITS'(s4_nn[1]) << (snbt_pkg::HALF_BITS + 1))
                    + (snbt_pkg::WIDE_BITS'(s4_nn[2]) << (2 * snbt_pkg::HALF_BITS));
    end
  end

  // Stage 6: endpoint-case answer, and partial products of radius times length.
  always_ff @(posedge clk) begin
    if (load[2]) begin
      s6_rej      <= s5_rej;
      s6_general  <= s5_general;
      s6_near_end <= (snbt_pkg::RK_BITS'(s5_sel) << snbt_pkg::FRAC_BITS) <= s5_rk;
      for (int j = 0; j < 2; j++) begin
        s6_p[0][j] <= snbt_pkg::SUM_BITS'(s5_rk[0 +: snbt_pkg::HALF_BITS]
                      * s5_len2[j*snbt_pkg::HALF_BITS +: snbt_pkg::HALF_BITS]);
        s6_p[1][j] <= snbt_pkg::SUM_BITS'(s5_rk[snbt_pkg::HALF_BITS +: snbt_pkg::HALF_BITS]
                      * s5_len2[j*snbt_pkg::HALF_BITS +: snbt_pkg::HALF_BITS]);
        s6_p[2][j] <= snbt_pkg::SUM_BITS'(s5_rk[snbt_pkg::RK_BITS-1:2*snbt_pkg::HALF_BITS]
                      * s5_len2[j*snbt_pkg::HALF_BITS +: snbt_pkg::HALF_BITS]);
      end
      s6_wl <= s5_wl;
      s6_nn <= s5_nn;
    end
  end

  // Stage 7: ww*len2 - num^2 is the squared cross product, never negative
  // for an interior projection; other cases do not use it.
  always_ff @(posedge clk) begin
    if (load[3]) begin
      s7_rej      <= s6_rej;
      s7_general  <= s6_general;
      s7_near_end <= s6_near_end;
      for (int j = 0; j < 2; j++) begin
        s7_q[j] <= snbt_pkg::Q_BITS'(s6_p[0][j])
                   + (snbt_pkg::Q_BITS'(s6_p[1][j]) << snbt_pkg::HALF_BITS)
                   + (snbt_pkg::Q_BITS'(s6_p[2][j]) << (2 * snbt_pkg::HALF_BITS));
      end
      s7_diff <= s6_wl - s6_nn;
    end
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      s8_rej      <= s7_rej;
      s8_general  <= s7_general;
      s8_near_end <= s7_near_end;
      s8_rhs      <= snbt_pkg::RHS_BITS'(s7_q[0])
                     + (snbt_pkg::RHS_BITS'(s7_q[1]) << snbt_pkg::HALF_BITS);
      s8_diff     <= s7_diff;
    end
  end

  // Stage 9 is the output register.
  always_ff @(posedge clk) begin
    if (load[5]) begin
      if (s8_rej) begin
        near <= 1'b0;
      end else if (s8_general) begin
        near <= (snbt_pkg::RHS_BITS'(s8_diff) << snbt_pkg::FRAC_BITS) <= s8_rhs;
      end else begin
        near <= s8_near_end;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/segment_near_box_test_unit.sv @@
// Segment-near-box test. Each beat on item_in carries a segment (two endpoints)
// and an axis-aligned box as signed 24-bit coordinates; each beat yields exactly
// one beat on result_out whose near bit is 1 when the segment passes the slab
// test and comes within the inflated bounding sphere of the box.
// The pipeline has nine register stages; a new item can be accepted every cycle
// while result_out is not stalled. The rate is set by the stage chain itself: no
// stage is deeper than one 26x26-bit multiply or one wide add or compare, so one
// item per cycle.
// Each stage carries a valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles are squeezed out. When result_out is stalled the
// pipeline keeps taking items until every stage is full; item_in.ready then
// drops, and nothing is lost or repeated.
// inflate_frac is written through cfg_we/cfg_wdata (units of 1/65536 added to
// the squared radius factor); it should change only while the pipeline is
// empty. Synchronous reset empties all stages and sets inflate_frac to 7.
`default_nettype none

module segment_near_box_test_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [snbt_pkg::FRAC_BITS-1:0]  cfg_wdata,
  snbt_item_if.sink                       item_in,
  snbt_result_if.source                   result_out
);

  logic [snbt_pkg::FRAC_BITS-1:0]  inflate_frac;
  logic [snbt_pkg::STAGES-1:0]     stage_valid;
  logic [snbt_pkg::STAGES-1:0]     stage_valid_next;
  logic [snbt_pkg::STAGES-1:0]     stage_load;
  snbt_pkg::sums_t                 sums;
  logic                            near;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflate_frac <= snbt_pkg::INFLATE_RESET;
    end else if (cfg_we) begin
      inflate_frac <= cfg_wdata;
    end
  end

  // A stage may load when it is empty or its contents move on this edge.
  always_comb begin
    stage_load[snbt_pkg::STAGES-1] = !stage_valid[snbt_pkg::STAGES-1] || result_out.ready;
    for (int k = snbt_pkg::STAGES - 2; k >= 0; k--) begin
      stage_load[k] = !stage_valid[k] || stage_load[k+1];
    end
    stage_valid_next = {stage_valid[snbt_pkg::STAGES-2:0], item_in.valid};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      for (int k = 0; k < snbt_pkg::STAGES; k++) begin
        if (stage_load[k]) begin
          stage_valid[k] <= stage_valid_next[k];
        end
      end
    end
  end

  assign item_in.ready        = stage_load[0];
  assign result_out.valid     = stage_valid[snbt_pkg::STAGES-1];
  assign result_out.data.near = near;

  snbt_front u_front (
    .clk  (clk),
    .load (stage_load[snbt_pkg::FRONT_STAGES-1:0]),
    .item (item_in.data),
    .sums (sums)
  );

  snbt_back u_back (
    .clk          (clk),
    .load         (stage_load[snbt_pkg::STAGES-1:snbt_pkg::FRONT_STAGES]),
    .inflate_frac (inflate_frac),
    .sums         (sums),
    .near         (near)
  );

endmodule

`default_nettype wire
